>>> src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/rswag_pkg.sv
package rswag_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int QUARTER_TURN = SINE_ENTRIES / 4;
    localparam int HALF_TURN    = SINE_ENTRIES / 2;
    localparam int SINE_PEAK    = 32767;

    // even sine index j = idx/2, quarter table over even quarter-wave points
    localparam int J_W      = $clog2(SINE_ENTRIES) - 1;
    localparam int M_W      = J_W - 2;
    localparam int QJ       = SINE_ENTRIES / 8;
    localparam int QTAB_N   = QJ + 1;
    localparam int TAB_A_W  = $clog2(QTAB_N);
    localparam int MAG_W    = 15;
    localparam int SINE_W   = 16;

    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W  = 10;
    localparam int AMP_W    = 8;
    localparam int PHASE_W  = 17;
    localparam int PROD_W   = SINE_W + AMP_W;
    localparam int OFF_W    = PROD_W - 15;
    localparam int LUMA_W   = 20;
    localparam int CHROMA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_AMPLITUDE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_AMPLITUDE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd4;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd240;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_DIV = PI_Q60 / HALF_TURN;
    localparam logic [63:0] PI_REM = PI_Q60 % HALF_TURN;

    typedef logic [QTAB_N-1:0][MAG_W-1:0] qtab_t;

    typedef struct packed {
        logic           valid;
        logic [J_W-1:0] index;
    } sine_req_t;

    typedef struct packed {
        logic                     valid;
        logic signed [SINE_W-1:0] sine;
        logic signed [SINE_W-1:0] cosine;
    } sine_rsp_t;

    // (a*b) >> 60, 64-bit wrapping
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
        ah  = a >> 32;
        al  = a & 64'hFFFF_FFFF;
        bh  = b >> 32;
        bl  = b & 64'hFFFF_FFFF;
        hi  = ah * bh;
        mid = ah * bl + al * bh;
        lo  = al * bl;
        return (hi << 4) + (mid >> 28) + (lo >> 60);
    endfunction

    // truncating long division by shift and subtract
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // truncated fixed-point sine series over the first quarter turn
    function automatic logic [MAG_W-1:0] quarter_sine(input int r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] denom;
        if (r == 0)
            return '0;
        if (r >= QUARTER_TURN)
            return MAG_W'(SINE_PEAK);
        x    = PI_DIV * 64'(r) + (PI_REM * 64'(r)) / HALF_TURN;
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 24; n++)
        begin
            if (term != 0)
            begin
                denom = 64'((2 * n) * (2 * n + 1));
                term  = udiv64(mul_q60(term, x2), denom);
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return MAG_W'(mul_q60(sum, 64'(SINE_PEAK)));
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i < QTAB_N; i++)
        begin
            t[i] = quarter_sine(2 * i);
        end
        return t;
    endfunction

    localparam qtab_t QSINE = build_qtab();

endpackage

>>> src/rswag_sine_rom.sv
module rswag_sine_rom
    import rswag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sine_req_t req,
    output sine_rsp_t rsp
);

    logic                     valid_reg;
    logic signed [SINE_W-1:0] sine_reg;
    logic signed [SINE_W-1:0] cosine_reg;
    logic signed [SINE_W-1:0] sine_next;
    logic signed [SINE_W-1:0] cosine_next;

    // quarter-wave symmetry on the even index
    function automatic logic signed [SINE_W-1:0] lookup(input logic [J_W-1:0] j);
        logic [1:0]               quad;
        logic [M_W-1:0]           m;
        logic [TAB_A_W-1:0]       addr;
        logic signed [SINE_W-1:0] mag;
        quad = j[J_W-1:J_W-2];
        m    = j[M_W-1:0];
        if (quad[0])
            addr = TAB_A_W'(QJ) - TAB_A_W'(m);
        else
            addr = TAB_A_W'(m);
        mag = $signed({1'b0, QSINE[addr]});
        if (quad[1])
            return -mag;
        return mag;
    endfunction

    always_comb
    begin
        sine_next   = lookup(req.index);
        cosine_next = lookup(req.index + J_W'(QJ));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        sine_reg   <= sine_next;
        cosine_reg <= cosine_next;
    end

    assign rsp = '{valid: valid_reg, sine: sine_reg, cosine: cosine_reg};

endmodule

>>> src/radial_sine_warp_address_gen_top.sv
// channel   | ports                                                 | handshake
// ----------+-------------------------------------------------------+-------------------------
// item in   | column, row, dist_code                                | start, busy
// result    | luma_src_addr, chroma_valid, first_/second_chroma_... | done strobe, one cycle
// config    | cfg_index, cfg_data                                   | cfg_we, no wait
//
// one item per clock; its result is registered at the end of each of these
// stages: phase multiply, sine table, amplitude multiply, clamp, row multiply, address add
// busy stays low; the receiver cannot stall, so the pipeline always advances
// reset clears the stage valid bits and loads the default frame settings
`include "assert_macros.svh"

module radial_sine_warp_address_gen_top
    import rswag_pkg::*;
#(
    parameter int MAX_DIM = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   column,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   dist_code,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic [LUMA_W-1:0]    luma_src_addr,
    output logic                 chroma_valid,
    output logic [CHROMA_W-1:0]  first_chroma_src_addr,
    output logic [CHROMA_W-1:0]  second_chroma_src_addr
);

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int PROD2_W = 2 * DIM_W;
    localparam int CMP_W   = (DIM_W + 1 > 12) ? DIM_W + 1 : 12;
    localparam int LATENCY = 6;

    // configuration
    logic [CFG_W-1:0]        frame_width_reg;
    logic [CFG_W-1:0]        frame_height_reg;
    logic signed [AMP_W-1:0] x_amp_reg;
    logic signed [AMP_W-1:0] y_amp_reg;
    logic signed [AMP_W-1:0] phase_step_reg;

    logic [DIM_W-1:0]    w_next;
    logic [DIM_W-1:0]    h_next;
    logic [DIM_W-1:0]    w_reg;
    logic [DIM_W-1:0]    maxx_reg;
    logic [DIM_W-1:0]    maxy_reg;
    logic [PROD2_W-1:0]  vsize_reg;
    logic [CHROMA_W-1:0] vbase1_reg;
    logic [CHROMA_W-1:0] vbase2_reg;

    // stage 1
    logic [PHASE_W-1:0] phase_next;
    logic               s1_valid_reg;
    logic [J_W-1:0]     s1_index_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic [COORD_W-1:0] s1_row_reg;

    // stage 2
    sine_req_t          sine_req;
    sine_rsp_t          sine_rsp;
    logic [COORD_W-1:0] s2_col_reg;
    logic [COORD_W-1:0] s2_row_reg;

    // stage 3
    logic [PROD_W-1:0]        xprod_next;
    logic [PROD_W-1:0]        yprod_next;
    logic                     s3_valid_reg;
    logic signed [PROD_W-1:0] s3_xprod_reg;
    logic signed [PROD_W-1:0] s3_yprod_reg;
    logic [COORD_W-1:0]       s3_col_reg;
    logic [COORD_W-1:0]       s3_row_reg;

    // stage 4
    logic signed [OFF_W-1:0] xoff;
    logic signed [OFF_W-1:0] yoff;
    logic signed [CMP_W-1:0] sum_x;
    logic signed [CMP_W-1:0] sum_y;
    logic signed [CMP_W-1:0] sum_xu;
    logic signed [CMP_W-1:0] sum_yu;
    logic                    s4_valid_reg;
    logic [DIM_W-1:0]        s4_dx_reg;
    logic [DIM_W-1:0]        s4_dy_reg;
    logic [DIM_W-1:0]        s4_dxu_reg;
    logic [DIM_W-1:0]        s4_dyu_reg;
    logic                    s4_cvalid_reg;

    // stage 5
    logic               s5_valid_reg;
    logic [PROD2_W-1:0] s5_py_reg;
    logic [PROD2_W-1:0] s5_pyu_reg;
    logic [DIM_W-1:0]   s5_dx_reg;
    logic [DIM_W-1:0]   s5_dxu_reg;
    logic               s5_cvalid_reg;

    // output
    logic [PROD2_W-1:0]  cbase_full;
    logic [CHROMA_W-1:0] cbase;
    logic                done_reg;
    logic [LUMA_W-1:0]   luma_reg;
    logic                cvalid_reg;
    logic [CHROMA_W-1:0] first_reg;
    logic [CHROMA_W-1:0] second_reg;

    function automatic logic [DIM_W-1:0] clamp(input logic signed [CMP_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
        logic signed [CMP_W-1:0] lim_s;
        lim_s = $signed(CMP_W'(lim));
        if (v < 0)
            return '0;
        if (v > lim_s)
            return lim;
        return DIM_W'(v);
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            x_amp_reg        <= '0;
            y_amp_reg        <= '0;
            phase_step_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_X_AMPLITUDE:  x_amp_reg        <= $signed(cfg_data[AMP_W-1:0]);
                CFG_Y_AMPLITUDE:  y_amp_reg        <= $signed(cfg_data[AMP_W-1:0]);
                CFG_PHASE_STEP:   phase_step_reg   <= $signed(cfg_data[AMP_W-1:0]);
                default: ;
            endcase
        end
    end

    // frame limits, saturated to the largest supported size
    always_comb
    begin
        if (32'(frame_width_reg) > MAX_DIM)
            w_next = DIM_W'(MAX_DIM);
        else
            w_next = DIM_W'(frame_width_reg);
        if (32'(frame_height_reg) > MAX_DIM)
            h_next = DIM_W'(MAX_DIM);
        else
            h_next = DIM_W'(frame_height_reg);
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        maxx_reg   <= (w_next >= DIM_W'(2)) ? w_next - DIM_W'(2) : '0;
        maxy_reg   <= (h_next >= DIM_W'(2)) ? h_next - DIM_W'(2) : '0;
        vsize_reg  <= PROD2_W'(w_next) * PROD2_W'(h_next);
        vbase1_reg <= CHROMA_W'(vsize_reg);
        vbase2_reg <= CHROMA_W'(vsize_reg + (vsize_reg >> 2));
    end

    // stage 1: phase = k * phase_step
    assign phase_next = PHASE_W'(dist_code[COORD_W-1:1])
                        * {{(PHASE_W - AMP_W){phase_step_reg[AMP_W-1]}}, phase_step_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start && !busy;
            s3_valid_reg  <= sine_rsp.valid;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            done_reg      <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg <= phase_next[J_W+3:4];
        s1_col_reg   <= column;
        s1_row_reg   <= row;
    end

    // stage 2: sine and cosine
    assign sine_req = '{valid: s1_valid_reg, index: s1_index_reg};

    rswag_sine_rom u_sine_rom (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sine_req),
        .rsp   (sine_rsp)
    );

    always_ff @(posedge clk)
    begin
        s2_col_reg <= s1_col_reg;
        s2_row_reg <= s1_row_reg;
    end

    // stage 3: amplitude scaling
    assign xprod_next = PROD_W'(sine_rsp.cosine)
                        * {{(PROD_W - AMP_W){x_amp_reg[AMP_W-1]}}, x_amp_reg};
    assign yprod_next = PROD_W'(sine_rsp.sine)
                        * {{(PROD_W - AMP_W){y_amp_reg[AMP_W-1]}}, y_amp_reg};

    always_ff @(posedge clk)
    begin
        s3_xprod_reg <= $signed(xprod_next);
        s3_yprod_reg <= $signed(yprod_next);
        s3_col_reg   <= s2_col_reg;
        s3_row_reg   <= s2_row_reg;
    end

    // stage 4: floor shift, offset and clamp
    always_comb
    begin
        xoff   = s3_xprod_reg[PROD_W-1:15];
        yoff   = s3_yprod_reg[PROD_W-1:15];
        sum_x  = CMP_W'(xoff) + $signed(CMP_W'(s3_col_reg));
        sum_y  = CMP_W'(yoff) + $signed(CMP_W'(s3_row_reg));
        sum_xu = CMP_W'(xoff) + $signed(CMP_W'(s3_col_reg[COORD_W-1:1]));
        sum_yu = CMP_W'(yoff) + $signed(CMP_W'(s3_row_reg[COORD_W-1:1]));
    end

    always_ff @(posedge clk)
    begin
        s4_dx_reg     <= clamp(sum_x, maxx_reg);
        s4_dy_reg     <= clamp(sum_y, maxy_reg);
        s4_dxu_reg    <= clamp(sum_xu, maxx_reg >> 1);
        s4_dyu_reg    <= clamp(sum_yu, maxy_reg >> 1);
        s4_cvalid_reg <= !s3_row_reg[0] && !s3_col_reg[0];
    end

    // stage 5: row offsets
    always_ff @(posedge clk)
    begin
        s5_py_reg     <= PROD2_W'(s4_dy_reg) * PROD2_W'(w_reg);
        s5_pyu_reg    <= PROD2_W'(s4_dyu_reg) * PROD2_W'(w_reg);
        s5_dx_reg     <= s4_dx_reg;
        s5_dxu_reg    <= s4_dxu_reg;
        s5_cvalid_reg <= s4_cvalid_reg;
    end

    // stage 6: addresses
    assign cbase_full = (s5_pyu_reg >> 1) + PROD2_W'(s5_dxu_reg);
    assign cbase      = CHROMA_W'(cbase_full);

    always_ff @(posedge clk)
    begin
        luma_reg   <= LUMA_W'(s5_py_reg + PROD2_W'(s5_dx_reg));
        cvalid_reg <= s5_cvalid_reg;
        if (s5_cvalid_reg)
        begin
            first_reg  <= vbase1_reg + cbase;
            second_reg <= vbase2_reg + cbase;
        end
        else
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
    end

    assign done                   = done_reg;
    assign luma_src_addr          = luma_reg;
    assign chroma_valid           = cvalid_reg;
    assign first_chroma_src_addr  = first_reg;
    assign second_chroma_src_addr = second_reg;

    `ASSERT_IMPLIES(a_done_latency, clk, rst_n, done, $past(start && !busy, LATENCY))
    `ASSERT_IMPLIES(a_chroma_parity, clk, rst_n, done, chroma_valid == $past(!row[0] && !column[0], LATENCY))
    `ASSERT_IMPLIES(a_chroma_zero, clk, rst_n, done && !chroma_valid, (first_chroma_src_addr == '0) && (second_chroma_src_addr == '0))

endmodule

>>> dv/warp_address_checker.sv
`timescale 1ns / 1ps

module warp_address_checker
    import rswag_pkg::*;
#(
    parameter int MAX_DIM = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [COORD_W-1:0]   column,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   dist_code,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 done,
    input  logic [LUMA_W-1:0]    luma_src_addr,
    input  logic                 chroma_valid,
    input  logic [CHROMA_W-1:0]  first_chroma_src_addr,
    input  logic [CHROMA_W-1:0]  second_chroma_src_addr,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [LUMA_W-1:0]   luma;
        logic                chroma_valid;
        logic [CHROMA_W-1:0] first_chroma;
        logic [CHROMA_W-1:0] second_chroma;
    } addr_set_t;

    localparam bit [63:0] PI_FIX60 = 64'h3243F6A8885A308D;

    int        sine_q15 [SINE_ENTRIES];
    int        width_reg;
    int        height_reg;
    int        x_amp;
    int        y_amp;
    int        phase_inc;
    addr_set_t addr_q [$];
    addr_set_t want;
    addr_set_t got;
    int        reported;

    // truncated (a*b) >> 60, split into 32-bit halves with 64-bit wrap
    function automatic bit [63:0] frac_mul60(input bit [63:0] a, input bit [63:0] b);
        bit [63:0] ah;
        bit [63:0] al;
        bit [63:0] bh;
        bit [63:0] bl;
        bit [63:0] mid_sum;
        bit [63:0] lo;
        ah      = a >> 32;
        al      = a & 64'hFFFF_FFFF;
        bh      = b >> 32;
        bl      = b & 64'hFFFF_FFFF;
        mid_sum = ah * bl + al * bh;
        lo      = al * bl;
        return ((ah * bh) << 4) + (mid_sum >> 28) + (lo >> 60);
    endfunction

    // sine magnitude over the first quarter turn, power series in q60
    function automatic int quarter_wave(input int r);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] term;
        bit [63:0] acc;
        bit [63:0] rr;
        if (r == 0)
            return 0;
        if (r >= QUARTER_TURN)
            return SINE_PEAK;
        rr   = 64'(r);
        x    = (PI_FIX60 / HALF_TURN) * rr + ((PI_FIX60 % HALF_TURN) * rr) / HALF_TURN;
        x2   = frac_mul60(x, x);
        term = x;
        acc  = x;
        for (int n = 1; n <= 24; n++)
        begin
            if (term != 0)
            begin
                term = frac_mul60(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
        end
        return int'(frac_mul60(acc, 64'(SINE_PEAK)));
    endfunction

    function automatic int clamp_to(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic addr_set_t warp_addresses(input logic [COORD_W-1:0] c,
                                                 input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] d);
        int        k;
        int        phase;
        bit [31:0] phase_bits;
        int        idx;
        int        xoff;
        int        yoff;
        int        w;
        int        h;
        int        maxx;
        int        maxy;
        int        dx;
        int        dy;
        int        dxu;
        int        dyu;
        longint    vsize;
        longint    cbase;
        addr_set_t res;
        k          = int'(d >> 1);
        phase      = k * phase_inc;
        phase_bits = phase;
        idx        = int'((phase_bits >> 3) & 32'(SINE_ENTRIES - 2));
        yoff       = (sine_q15[idx] * y_amp) >>> 15;
        xoff       = (sine_q15[(idx + QUARTER_TURN) % SINE_ENTRIES] * x_amp) >>> 15;
        w          = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
        h          = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
        maxx       = (w >= 2) ? w - 2 : 0;
        maxy       = (h >= 2) ? h - 2 : 0;
        dx         = clamp_to(xoff + int'(c), maxx);
        dy         = clamp_to(yoff + int'(r), maxy);
        dxu        = clamp_to(xoff + int'(c >> 1), maxx / 2);
        dyu        = clamp_to(yoff + int'(r >> 1), maxy / 2);
        res.luma   = LUMA_W'(longint'(dy) * w + dx);
        res.chroma_valid = !r[0] && !c[0];
        if (res.chroma_valid)
        begin
            vsize             = longint'(w) * h;
            cbase             = ((longint'(dyu) * w) >>> 1) + dxu;
            res.first_chroma  = CHROMA_W'(vsize + cbase);
            res.second_chroma = CHROMA_W'(vsize + (vsize >>> 2) + cbase);
        end
        else
        begin
            res.first_chroma  = '0;
            res.second_chroma = '0;
        end
        return res;
    endfunction

    initial
    begin
        int q;
        int r;
        int v;
        fail_count = 0;
        reported   = 0;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            q = i / QUARTER_TURN;
            r = i % QUARTER_TURN;
            v = (q % 2 == 1) ? quarter_wave(QUARTER_TURN - r) : quarter_wave(r);
            sine_q15[i] = (q >= 2) ? -v : v;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= int'(RST_FRAME_WIDTH);
            height_reg <= int'(RST_FRAME_HEIGHT);
            x_amp      <= 0;
            y_amp      <= 0;
            phase_inc  <= 0;
            addr_q.delete();
            pending    <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{luma_src_addr, chroma_valid, first_chroma_src_addr,
                        second_chroma_src_addr};
                if (addr_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (reported < 10)
                    begin
                        reported = reported + 1;
                        $display("%0t: result with no item outstanding: luma %0d", $realtime,
                                 luma_src_addr);
                    end
                end
                else
                begin
                    want = addr_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        if (reported < 10)
                        begin
                            reported = reported + 1;
                            $display("%0t: mismatch luma exp %0d got %0d, cvalid exp %0b got %0b",
                                     $realtime, want.luma, got.luma, want.chroma_valid,
                                     got.chroma_valid);
                            $display("    first chroma exp %0d got %0d, second exp %0d got %0d",
                                     want.first_chroma, got.first_chroma,
                                     want.second_chroma, got.second_chroma);
                        end
                    end
                end
            end
            if (start && !busy)
                addr_q.push_back(warp_addresses(column, row, dist_code));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  <= int'(cfg_data);
                    CFG_FRAME_HEIGHT: height_reg <= int'(cfg_data);
                    CFG_X_AMPLITUDE:  x_amp      <= int'($signed(cfg_data[AMP_W-1:0]));
                    CFG_Y_AMPLITUDE:  y_amp      <= int'($signed(cfg_data[AMP_W-1:0]));
                    CFG_PHASE_STEP:   phase_inc  <= int'($signed(cfg_data[AMP_W-1:0]));
                    default:          ;
                endcase
            end
            pending <= addr_q.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rswag_pkg::*;

    localparam int MAX_DIM     = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 12;
    localparam int SEGMENTS    = 10;
    localparam int SEG_ITEMS   = 115;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   dist_code;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    logic [LUMA_W-1:0]    luma_src_addr;
    logic                 chroma_valid;
    logic [CHROMA_W-1:0]  first_chroma_src_addr;
    logic [CHROMA_W-1:0]  second_chroma_src_addr;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    int                   idle_pct;
    int                   cur_w;
    int                   cur_h;

    radial_sine_warp_address_gen_top #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .start                  (start),
        .busy                   (busy),
        .column                 (column),
        .row                    (row),
        .dist_code              (dist_code),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .done                   (done),
        .luma_src_addr          (luma_src_addr),
        .chroma_valid           (chroma_valid),
        .first_chroma_src_addr  (first_chroma_src_addr),
        .second_chroma_src_addr (second_chroma_src_addr)
    );

    warp_address_checker #(
        .MAX_DIM(MAX_DIM)
    ) u_checker (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .start                  (start),
        .busy                   (busy),
        .column                 (column),
        .row                    (row),
        .dist_code              (dist_code),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .done                   (done),
        .luma_src_addr          (luma_src_addr),
        .chroma_valid           (chroma_valid),
        .first_chroma_src_addr  (first_chroma_src_addr),
        .second_chroma_src_addr (second_chroma_src_addr),
        .fail_count             (fail_count),
        .pending                (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stop issuing and let the pipeline drain
    task automatic drain();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            cur_w = value;
        else if (idx == CFG_FRAME_HEIGHT)
            cur_h = value;
    endtask

    task automatic load_frame(input int w, input int h, input int xa, input int ya,
                              input int ps);
        drain();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_X_AMPLITUDE, xa);
        write_reg(CFG_Y_AMPLITUDE, ya);
        write_reg(CFG_PHASE_STEP, ps);
    endtask

    task automatic send_item(input int c, input int r, input int d);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start     = 1'b1;
        column    = COORD_W'(c);
        row       = COORD_W'(r);
        dist_code = COORD_W'(d);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 3);
            1:       return MAX_DIM;
            2:       return $urandom_range(MAX_DIM + 1, 2047);
            3:       return 4;
            default: return $urandom_range(4, MAX_DIM);
        endcase
    endfunction

    function automatic int pick_amp();
        case ($urandom_range(0, 7))
            0:       return 127;
            1:       return 128;
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    initial
    begin
        int lim_c;
        int lim_r;
        int c;
        int r;
        cycles    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        column    = '0;
        row       = '0;
        dist_code = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data  = '0;
        idle_pct  = 0;
        cur_w     = int'(RST_FRAME_WIDTH);
        cur_h     = int'(RST_FRAME_HEIGHT);
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset defaults, no warp
        send_item(0, 0, 0);
        send_item(1023, 1022, 1022);
        send_item(319, 239, 1);
        send_item(318, 238, 511);

        // full size frame, strongest warp both ways
        load_frame(MAX_DIM, MAX_DIM, 127, 128, 127);
        send_item(0, 0, 0);
        send_item(1023, 1022, 1022);
        send_item(512, 511, 1021);
        send_item(1, 0, 300);
        send_item(0, 1, 301);
        send_item(600, 400, 64);
        load_frame(MAX_DIM, MAX_DIM, 128, 127, 128);
        send_item(0, 0, 1022);
        send_item(1023, 1022, 2);
        send_item(511, 512, 700);
        send_item(100, 200, 255);

        // tiny frame, clamp limits collapse to zero
        load_frame(1, 0, 128, 127, 128);
        send_item(0, 0, 10);
        send_item(1023, 1022, 1022);
        send_item(3, 5, 77);

        // oversized width saturates, odd height, writes to unused indexes
        load_frame(2047, 241, 2047, 1920, 1);
        write_reg(CFG_IDX_LAST, 2047);
        write_reg(CFG_PHASE_STEP + CFG_IDX_W'(1), 0);
        send_item(1023, 240, 1022);
        send_item(0, 0, 8);
        send_item(321, 119, 160);
        send_item(2, 2, 999);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_pct = (seg < 4) ? 15 : ((seg < 7) ? 67 : 0);
            load_frame(pick_dim(), pick_dim(), pick_amp(), pick_amp(), pick_amp());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(CFG_PHASE_STEP) + 1,
                                                    int'(CFG_IDX_LAST))),
                          int'($urandom_range(0, 2047)));
            lim_c = (cur_w > MAX_DIM) ? MAX_DIM - 1 : ((cur_w > 0) ? cur_w - 1 : 0);
            lim_r = (cur_h > MAX_DIM) ? MAX_DIM - 2 : ((cur_h > 1) ? cur_h - 2 : 0);
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    c = $urandom_range(0, lim_c);
                    r = $urandom_range(0, lim_r);
                end
                else
                begin
                    c = $urandom_range(0, 1023);
                    r = $urandom_range(0, 1022);
                end
                send_item(c, r, $urandom_range(0, 1022));
            end
        end

        drain();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
